/* rtl/core/lock_with_waiter_list_assert.svh */
// ----------------------------------------------------------------------------
// Lock with waiter list - assertion macros
// Short forms for the clocked checks used in the port checker.
// ----------------------------------------------------------------------------
`ifndef LOCK_WITH_WAITER_LIST_ASSERT_SVH
`define LOCK_WITH_WAITER_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LWL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock_with_waiter_list: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lock_with_waiter_list: check failed");

`endif

/* rtl/core/lwl_pkg.sv */
// ----------------------------------------------------------------------------
// Lock with waiter list - package
// Shared widths, command codes, controller states and cell operations.
// ----------------------------------------------------------------------------
package lwl_pkg;

    localparam int CMD_BITS       = 2;
    localparam int REQ_BITS       = 8;
    localparam int NODE_BITS      = 8;
    localparam int WAIT_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF    = 8;
    // Count width at the largest supported list depth (127).
    localparam int CNT_MAX_BITS   = 7;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_RESERVE = 2'd2,
        CMD_CANCEL  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_NOTE
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic [CNT_MAX_BITS-1:0]   count;
    } t_cell_ctrl;

endpackage

/* rtl/core/lwl_if.sv */
// ----------------------------------------------------------------------------
// Lock with waiter list - channel interfaces
// Command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lwl_in_if import lwl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_BITS-1:0] command;
    logic [REQ_BITS-1:0] requester;

    modport source (output valid, command, requester, input ready);
    modport sink   (input valid, command, requester, output ready);
endinterface

interface lwl_out_if import lwl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic                 success;
    logic [NODE_BITS-1:0] node_id;
    logic                 overflow;
    logic                 last;

    modport source (output valid, kind, success, node_id, overflow, last, input ready);
    modport sink   (input valid, kind, success, node_id, overflow, last, output ready);
endinterface

/* rtl/core/lock_with_waiter_list.sv */
// ----------------------------------------------------------------------------
// Lock with waiter list - top level
// A single lock with an ordered list of waiting requesters held in a row
// of cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one command word (acquire, release, reserve, cancel) and a
//   requester id. o_out returns result words: one status word per command,
//   then, after a successful release, one notice word per waiter in list
//   order; last marks the final word of a command.
//   A command passes through the look and execute states before its status
//   word is registered; a release with N waiters then adds N notices, one
//   per cycle while the receiver takes them, as the cell row rotates by one
//   position per notice. The next command is accepted in the cycle after
//   the last word of the previous one is loaded.
//   Matches are taken in a registered compare across all cells.
//   A stalled receiver holds the output register; the controller waits and
//   no state changes until the word is taken.
//   Reset clears the lock, the holder and the list count; stored ids are
//   not cleared and are read only below the count.
// ----------------------------------------------------------------------------
module lock_with_waiter_list import lwl_pkg::*; #(
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lwl_in_if.sink            i_in,
    lwl_out_if.source         o_out
);

    localparam int CNT_BITS = $clog2(WAIT_DEPTH + 1);

    t_state               r_state;
    t_state               n_state;
    t_cmd                 r_cmd;
    logic [ID_BITS-1:0]   r_key;
    logic [ID_BITS-1:0]   w_key_in;
    logic                 r_held;
    logic                 n_held;
    logic [ID_BITS-1:0]   r_holder;
    logic [ID_BITS-1:0]   n_holder;
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;
    logic [CNT_BITS-1:0]  r_left;
    logic [CNT_BITS-1:0]  n_left;

    logic                 r_out_valid;
    logic                 r_out_kind;
    logic                 r_out_success;
    logic [ID_BITS-1:0]   r_out_id;
    logic                 r_out_ovf;
    logic                 r_out_last;
    logic                 w_load_out;
    logic                 w_out_kind;
    logic                 w_out_success;
    logic [ID_BITS-1:0]   w_out_id;
    logic                 w_out_ovf;
    logic                 w_out_last;

    logic                 w_free;
    logic                 w_accept;
    logic                 w_ok;
    logic                 w_ovf;
    logic                 w_notify;
    logic                 w_present;
    logic                 w_full;
    t_cell_op             w_op;
    t_cell_op             w_cell_op;
    t_cell_ctrl           w_ctrl;

    logic [ID_BITS-1:0]   w_id      [WAIT_DEPTH];
    logic [ID_BITS-1:0]   w_next_id [WAIT_DEPTH];
    logic [WAIT_DEPTH-1:0] w_match;
    logic [WAIT_DEPTH:0]  w_hit;

    assign w_free    = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept  = i_in.valid && i_in.ready;
    assign w_present = |w_match;
    assign w_full    = (r_count == CNT_BITS'(WAIT_DEPTH));

    // requester bits above ID_BITS are dropped, missing ones read as zero
    for (genvar b = 0; b < ID_BITS; b++) begin : g_key
        if (b < REQ_BITS) begin : g_bit
            assign w_key_in[b] = i_in.requester[b];
        end else begin : g_zero
            assign w_key_in[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < NODE_BITS; b++) begin : g_node
        if (b < ID_BITS) begin : g_bit
            assign o_out.node_id[b] = r_out_id[b];
        end else begin : g_zero
            assign o_out.node_id[b] = 1'b0;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.kind     = r_out_kind;
    assign o_out.success  = r_out_success;
    assign o_out.overflow = r_out_ovf;
    assign o_out.last     = r_out_last;

    // ---------------------------------------------------------------- cells
    assign w_ctrl.op    = w_cell_op;
    assign w_ctrl.count = CNT_MAX_BITS'(r_count);
    assign w_hit[0]     = 1'b0;

    for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
        // the tail of the occupied run wraps to the head for rotation
        if (i + 1 < WAIT_DEPTH) begin : g_mid
            assign w_next_id[i] = (CNT_BITS'(i + 1) < r_count) ? w_id[i + 1] : w_id[0];
        end else begin : g_end
            assign w_next_id[i] = w_id[0];
        end

        lwl_cell #(
            .IDX     (i),
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_key     (r_key),
            .i_next_id (w_next_id[i]),
            .i_hit_in  (w_hit[i]),
            .o_id      (w_id[i]),
            .o_hit_out (w_hit[i + 1]),
            .o_match   (w_match[i])
        );
    end

    // ------------------------------------------------------------ decision
    always_comb begin
        w_ok     = 1'b0;
        w_ovf    = 1'b0;
        w_notify = 1'b0;
        n_held   = r_held;
        n_holder = r_holder;
        n_count  = r_count;
        w_op     = CELL_HOLD;
        unique case (r_cmd)
            CMD_ACQUIRE: begin
                if (!r_held) begin
                    w_ok     = 1'b1;
                    n_held   = 1'b1;
                    n_holder = r_key;
                end else if (!w_present) begin
                    if (w_full) begin
                        w_ovf = 1'b1;
                    end else begin
                        w_op    = CELL_APPEND;
                        n_count = r_count + 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                if (r_held && (r_holder == r_key)) begin
                    w_ok     = 1'b1;
                    w_notify = 1'b1;
                    n_held   = 1'b0;
                end
            end
            CMD_RESERVE: begin
                if (!w_present) begin
                    if (w_full) begin
                        w_ovf = 1'b1;
                    end else begin
                        w_ok    = 1'b1;
                        w_op    = CELL_APPEND;
                        n_count = r_count + 1'b1;
                    end
                end
            end
            CMD_CANCEL: begin
                if (w_present) begin
                    w_ok    = 1'b1;
                    w_op    = CELL_REMOVE;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    // ----------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_LOOK;
            S_LOOK: n_state = S_EXEC;
            S_EXEC: begin
                if (w_free) begin
                    n_state = (w_notify && (r_count != '0)) ? S_NOTE : S_IDLE;
                end
            end
            S_NOTE: begin
                if (w_free && (r_left == CNT_BITS'(1))) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // -------------------------------------------------------------- outputs
    always_comb begin
        w_load_out    = 1'b0;
        w_out_kind    = 1'b0;
        w_out_success = 1'b0;
        w_out_id      = r_key;
        w_out_ovf     = 1'b0;
        w_out_last    = 1'b1;
        n_left        = r_left;
        unique case (r_state)
            S_IDLE, S_LOOK: begin
                w_load_out = 1'b0;
            end
            S_EXEC: begin
                w_load_out    = w_free;
                w_out_success = w_ok;
                w_out_ovf     = w_ovf;
                w_out_last    = !(w_notify && (r_count != '0));
                if (w_free) n_left = r_count;
            end
            S_NOTE: begin
                w_load_out = w_free;
                w_out_kind = 1'b1;
                w_out_id   = w_id[0];
                w_out_last = (r_left == CNT_BITS'(1));
                if (w_free) n_left = r_left - 1'b1;
            end
            default: begin
                w_load_out = 1'b0;
            end
        endcase
    end

    // hold the cells unless the controller commits a step this cycle
    always_comb begin
        w_cell_op = CELL_HOLD;
        if (w_free) begin
            if (r_state == S_EXEC) begin
                w_cell_op = w_op;
            end else if (r_state == S_NOTE) begin
                w_cell_op = CELL_ROTATE;
            end
        end
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= 1'b0;
            r_holder    <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            // state changes only when the status word is loaded
            if ((r_state == S_EXEC) && w_free) begin
                r_held   <= n_held;
                r_holder <= n_holder;
                r_count  <= n_count;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(i_in.command);
            r_key <= w_key_in;
        end
        if (w_load_out) begin
            r_out_kind    <= w_out_kind;
            r_out_success <= w_out_success;
            r_out_id      <= w_out_id;
            r_out_ovf     <= w_out_ovf;
            r_out_last    <= w_out_last;
        end
    end

endmodule

/* rtl/core/lwl_cell.sv */
// ----------------------------------------------------------------------------
// Lock with waiter list - list cell
// Holds one waiter id, takes the key on an append at its position, flags a
// key match and takes its next-id input when the list is compacted or rotated.
// ----------------------------------------------------------------------------
module lwl_cell import lwl_pkg::*; #(
    parameter int IDX     = 0,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic [ID_BITS-1:0] i_key,
    input  logic [ID_BITS-1:0] i_next_id,
    input  logic               i_hit_in,
    output logic [ID_BITS-1:0] o_id,
    output logic               o_hit_out,
    output logic               o_match
);

    localparam logic [CNT_MAX_BITS-1:0] POS = CNT_MAX_BITS'(IDX);

    logic [ID_BITS-1:0] r_id;
    logic [ID_BITS-1:0] n_id;
    logic               r_match;
    logic               w_occ;

    assign w_occ     = POS < i_ctrl.count;
    assign o_id      = r_id;
    assign o_match   = r_match;
    assign o_hit_out = i_hit_in | r_match;

    always_comb begin
        n_id = r_id;
        case (i_ctrl.op)
            CELL_APPEND: begin
                if (POS == i_ctrl.count) n_id = i_key;
            end
            CELL_REMOVE: begin
                // close the gap: every cell at or past the hit takes its neighbor
                if (o_hit_out) n_id = i_next_id;
            end
            CELL_ROTATE: begin
                if (w_occ) n_id = i_next_id;
            end
            default: n_id = r_id;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_match <= w_occ && (r_id == i_key);
    end

endmodule

/* rtl/core/lwl_checker.sv */
// ----------------------------------------------------------------------------
// Lock with waiter list - port checker
// Checks handshake and result-word rules seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "lock_with_waiter_list_assert.svh"

module lwl_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_kind,
    input logic i_out_success,
    input logic i_out_overflow,
    input logic i_out_last
);

    // hold a stalled result word
    `LWL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // one command at a time: drop ready after an accepted word
    `LWL_ASSERT_NEXT(a_in_one, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // notices carry no status flags
    `LWL_ASSERT_NOW(a_note_flags, i_clk, i_rst_n, i_out_valid && i_out_kind,
                    !i_out_success && !i_out_overflow)

    // a status word followed by notices reports success without overflow
    `LWL_ASSERT_NOW(a_status_more, i_clk, i_rst_n, i_out_valid && !i_out_kind && !i_out_last,
                    i_out_success && !i_out_overflow)

    // a refused append never reports success
    `LWL_ASSERT_NOW(a_ovf_fail, i_clk, i_rst_n, i_out_valid && i_out_overflow,
                    !i_out_success && i_out_last)

endmodule

bind lock_with_waiter_list lwl_checker u_lwl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_kind     (o_out.kind),
    .i_out_success  (o_out.success),
    .i_out_overflow (o_out.overflow),
    .i_out_last     (o_out.last)
);
